### sv/tcw_pkg.sv
// Shared types and constants of the text console cell writer.
package tcw_pkg;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMNS    = 2'd0,
		REG_ROWS       = 2'd1,
		REG_FOREGROUND = 2'd2,
		REG_BACKGROUND = 2'd3
	} reg_idx_t;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] bg;
		logic [7:0] fg;
		logic [7:0] ch;
	} cell_t;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam logic [6:0] RST_COLUMNS = 7'd80;
	localparam logic [5:0] RST_ROWS    = 6'd25;
	localparam logic [7:0] RST_FG      = 8'd7;
	localparam logic [7:0] RST_BG      = 8'd0;

	localparam cell_t RESET_BLANK = '{bg: RST_BG, fg: RST_FG, ch: CH_SPACE};

endpackage

### sv/tcw_ifs.sv
// Handshake channels of the text console cell writer.
interface tcw_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_byte;
	logic [6:0] query_column;
	logic [5:0] query_row;
	modport source (output valid, kind, char_byte, query_column, query_row, input ready);
	modport sink (input valid, kind, char_byte, query_column, query_row, output ready);
endinterface

interface tcw_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] cursor_column;
	logic [5:0] cursor_row;
	logic [7:0] cell_char;
	logic [7:0] cell_foreground;
	logic [7:0] cell_background;
	modport source (output valid, cursor_column, cursor_row, cell_char, cell_foreground,
		cell_background, input ready);
	modport sink (input valid, cursor_column, cursor_row, cell_char, cell_foreground,
		cell_background, output ready);
endinterface

interface tcw_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/tcw_grid_ram.sv
// Cell grid memory with one write port and one registered read port.
module tcw_grid_ram #(
	parameter int DEPTH = 6000,
	parameter int AW = 13
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  tcw_pkg::cell_t        wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output tcw_pkg::cell_t        rdata
);
	tcw_pkg::cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### sv/text_console_cell_writer_unit.sv
// Top level of the text console cell writer: cursor control, scroll sequencer and grid.
// A tab writes spaces up to the next column that is a multiple of four.
// A scroll with more than one row in use first copies each row up by one, and
// every scroll blanks the bottom row across the columns in use.
// One item is in work at a time; the next is taken once the last result is read.
// After reset every cell of the grid is cleared to a blank, with no item taken meanwhile.
module text_console_cell_writer_unit #(
	parameter int MAX_COLS = 120,
	parameter int MAX_ROWS = 50
) (
	input  logic      clk,
	input  logic      arst_n,
	tcw_in_if.sink    item,
	tcw_out_if.source result,
	tcw_cfg_if.sink   cfg
);
	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_TAB, ST_COPY, ST_BLANK, ST_QUERY
	} state_t;

	state_t         state_q, state_d;
	logic [6:0]     col_q, col_d;
	logic [5:0]     row_q, row_d;
	logic [6:0]     columns_q;
	logic [5:0]     rows_q;
	logic [7:0]     fg_q, bg_q;
	logic [AW-1:0]  ptr_q, ptr_d, last_q, last_d, base_q, base_d;
	logic [AW-1:0]  dst_s1, dst_d;
	logic           copy_v_s1, copy_v_d;
	logic           rd_act_q, rd_act_d;
	logic [6:0]     bcol_q, bcol_d;
	logic [2:0]     left_q, left_d;
	logic           tabm_q, tabm_d;
	logic           oob_q, oob_d;
	logic           out_valid_q;
	logic [6:0]     out_col_q;
	logic [5:0]     out_row_q;
	tcw_pkg::cell_t out_cell_q, cell_o;
	logic           fin, start_scr;

	logic           we, re;
	logic [AW-1:0]  waddr, raddr;
	tcw_pkg::cell_t wdata, rdata, blank_cfg;

	logic [6:0]     nc;
	logic [5:0]     nr;
	logic [7:0]     col_inc;
	logic [6:0]     row_inc;
	logic           p_wrap, p_scr, nl_scr;
	logic [6:0]     p_col;
	logic [5:0]     p_row;
	logic [6:0]     bs_col;
	logic [5:0]     bs_row;
	logic           bs_ok;
	logic           in_acc;
	logic           q_in_grid;
	logic [AW-1:0]  base_c;

	function automatic logic [AW-1:0] cell_addr(input logic [5:0] r, input logic [6:0] c);
		cell_addr = AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
	endfunction

	function automatic logic in_grid(input logic [5:0] r, input logic [6:0] c);
		in_grid = ({2'b0, c} < 9'(MAX_COLS)) && ({2'b0, r} < 8'(MAX_ROWS));
	endfunction

	tcw_grid_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	assign nc = ({2'b0, columns_q} > 9'(MAX_COLS)) ? 7'(MAX_COLS) : columns_q;
	assign nr = ({2'b0, rows_q} > 8'(MAX_ROWS)) ? 6'(MAX_ROWS) : rows_q;
	assign blank_cfg = '{bg: bg_q, fg: fg_q, ch: tcw_pkg::CH_SPACE};

	assign col_inc = {1'b0, col_q} + 8'd1;
	assign row_inc = {1'b0, row_q} + 7'd1;
	assign p_wrap = col_inc >= {1'b0, nc};
	assign nl_scr = row_inc >= {1'b0, nr};
	assign p_scr = p_wrap && nl_scr;
	assign p_col = p_wrap ? 7'd0 : col_inc[6:0];
	assign p_row = (p_wrap && !nl_scr) ? row_inc[5:0] : row_q;

	assign bs_ok = (col_q != 7'd0) || (row_q != 6'd0);
	assign bs_col = (col_q != 7'd0) ? col_q - 7'd1 : nc - 7'd1;
	assign bs_row = (col_q != 7'd0) ? row_q : row_q - 6'd1;

	assign base_c = AW'(AW'(nr - 6'd1) * AW'(MAX_COLS));
	assign q_in_grid = in_grid(item.query_row, item.query_column);

	assign item.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign in_acc = item.valid && item.ready;
	assign cfg.ready = 1'b1;

	assign result.valid = out_valid_q;
	assign result.cursor_column = out_col_q;
	assign result.cursor_row = out_row_q;
	assign result.cell_char = out_cell_q.ch;
	assign result.cell_foreground = out_cell_q.fg;
	assign result.cell_background = out_cell_q.bg;

	always_comb begin
		state_d = state_q;
		col_d = col_q;
		row_d = row_q;
		ptr_d = ptr_q;
		last_d = last_q;
		base_d = base_q;
		rd_act_d = rd_act_q;
		bcol_d = bcol_q;
		left_d = left_q;
		tabm_d = tabm_q;
		oob_d = oob_q;
		copy_v_d = 1'b0;
		dst_d = ptr_q - AW'(MAX_COLS);
		fin = 1'b0;
		start_scr = 1'b0;
		cell_o = '0;
		we = 1'b0;
		waddr = cell_addr(row_q, col_q);
		wdata = blank_cfg;
		re = 1'b0;
		raddr = ptr_q;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = ptr_q;
				wdata = tcw_pkg::RESET_BLANK;
				if (ptr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					tabm_d = 1'b0;
					if (item.kind == tcw_pkg::KIND_QUERY) begin
						re = q_in_grid;
						raddr = cell_addr(item.query_row, item.query_column);
						oob_d = !q_in_grid;
						state_d = ST_QUERY;
					end else if (nc == 7'd0 || nr == 6'd0) begin
						fin = 1'b1;
					end else begin
						case (item.char_byte) inside
							tcw_pkg::CH_LF: begin
								col_d = 7'd0;
								if (nl_scr) begin
									start_scr = 1'b1;
								end else begin
									row_d = row_inc[5:0];
									fin = 1'b1;
								end
							end
							tcw_pkg::CH_CR: begin
								col_d = 7'd0;
								fin = 1'b1;
							end
							tcw_pkg::CH_BS, tcw_pkg::CH_DEL: begin
								if (bs_ok) begin
									col_d = bs_col;
									row_d = bs_row;
									we = in_grid(bs_row, bs_col);
									waddr = cell_addr(bs_row, bs_col);
								end
								fin = 1'b1;
							end
							tcw_pkg::CH_TAB: begin
								left_d = 3'd4 - {1'b0, col_q[1:0]};
								tabm_d = 1'b1;
								state_d = ST_TAB;
							end
							default: begin
								if (item.char_byte >= tcw_pkg::CH_SPACE) begin
									we = in_grid(row_q, col_q);
									wdata = '{bg: bg_q, fg: fg_q, ch: item.char_byte};
									col_d = p_col;
									row_d = p_row;
									if (p_scr) begin
										start_scr = 1'b1;
									end else begin
										fin = 1'b1;
									end
								end else begin
									fin = 1'b1;
								end
							end
						endcase
					end
				end
			end
			ST_TAB: begin
				we = in_grid(row_q, col_q);
				col_d = p_col;
				row_d = p_row;
				left_d = left_q - 3'd1;
				if (p_scr) begin
					start_scr = 1'b1;
				end else if (left_q == 3'd1) begin
					state_d = ST_IDLE;
					fin = 1'b1;
				end
			end
			ST_COPY: begin
				if (rd_act_q) begin
					re = 1'b1;
					raddr = ptr_q;
					copy_v_d = 1'b1;
					if (ptr_q == last_q) begin
						rd_act_d = 1'b0;
					end else begin
						ptr_d = ptr_q + AW'(1);
					end
				end
				if (copy_v_s1) begin
					we = 1'b1;
					waddr = dst_s1;
					wdata = rdata;
				end
				if (!rd_act_q && !copy_v_s1) begin
					state_d = ST_BLANK;
				end
			end
			ST_BLANK: begin
				we = 1'b1;
				waddr = base_q + AW'(bcol_q);
				bcol_d = bcol_q + 7'd1;
				if (bcol_q == nc - 7'd1) begin
					col_d = 7'd0;
					row_d = nr - 6'd1;
					if (tabm_q && left_q != 3'd0) begin
						state_d = ST_TAB;
					end else begin
						state_d = ST_IDLE;
						fin = 1'b1;
					end
				end
			end
			ST_QUERY: begin
				state_d = ST_IDLE;
				fin = 1'b1;
				cell_o = oob_q ? '0 : rdata;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (start_scr) begin
			col_d = 7'd0;
			base_d = base_c;
			bcol_d = 7'd0;
			if (nr > 6'd1) begin
				ptr_d = AW'(MAX_COLS);
				last_d = base_c + AW'(MAX_COLS - 1);
				rd_act_d = 1'b1;
				state_d = ST_COPY;
			end else begin
				state_d = ST_BLANK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			col_q <= '0;
			row_q <= '0;
			ptr_q <= '0;
			rd_act_q <= 1'b0;
			copy_v_s1 <= 1'b0;
			tabm_q <= 1'b0;
			left_q <= '0;
			bcol_q <= '0;
			out_valid_q <= 1'b0;
			columns_q <= tcw_pkg::RST_COLUMNS;
			rows_q <= tcw_pkg::RST_ROWS;
			fg_q <= tcw_pkg::RST_FG;
			bg_q <= tcw_pkg::RST_BG;
		end else begin
			state_q <= state_d;
			col_q <= col_d;
			row_q <= row_d;
			ptr_q <= ptr_d;
			rd_act_q <= rd_act_d;
			copy_v_s1 <= copy_v_d;
			tabm_q <= tabm_d;
			left_q <= left_d;
			bcol_q <= bcol_d;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				unique case (tcw_pkg::reg_idx_t'(cfg.index))
					tcw_pkg::REG_COLUMNS:    columns_q <= cfg.data[6:0];
					tcw_pkg::REG_ROWS:       rows_q <= cfg.data[5:0];
					tcw_pkg::REG_FOREGROUND: fg_q <= cfg.data;
					tcw_pkg::REG_BACKGROUND: bg_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		last_q <= last_d;
		base_q <= base_d;
		dst_s1 <= dst_d;
		oob_q <= oob_d;
		if (fin) begin
			out_col_q <= col_d;
			out_row_q <= row_d;
			out_cell_q <= cell_o;
		end
	end
endmodule
